/* sv/gbdd_pkg.sv */
// ----------------------------------------------------------------------------
// gbdd_pkg: shared definitions for the gyro band dwell detector
// Register map codes, band status codes, sequencer states and default sizes.
// ----------------------------------------------------------------------------
package gbdd_pkg;

  // Default sizes for the top-level parameters
  localparam int WINDOW_DEF    = 100;
  localparam int RATE_BITS_DEF = 16;

  // Configuration port
  localparam int ADDR_W    = 5;
  localparam int REG_IDX_W = 3;
  localparam int DATA_W    = 32;

  localparam logic [REG_IDX_W-1:0] REG_ARMED       = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_AXIS_SELECT = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_LOW_BOUND   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_HIGH_BOUND  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_DWELL_MS    = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_RATE_OFFSET = 3'd5;

  localparam logic [7:0] RATE_OFFSET_RST = 8'd2;

  // Band status codes
  localparam logic [1:0] STATUS_IDLE    = 2'd0;
  localparam logic [1:0] STATUS_IN_BAND = 2'd1;
  localparam logic [1:0] STATUS_BELOW   = 2'd2;
  localparam logic [1:0] STATUS_ABOVE   = 2'd3;

  // Result word: band_status, movement_detected, averaged_rate, zero pad
  localparam int AVG_W   = 17;
  localparam int AVG_MAX = 65535;
  localparam int AVG_MIN = -65536;
  localparam int OUT_W   = 24;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_UPDATE,
    S_DIV,
    S_CLASS
  } state_t;

endpackage

/* sv/gyro_band_dwell_detector.sv */
// ----------------------------------------------------------------------------
// gyro_band_dwell_detector: moving-average band comparator with dwell timer
// Averages |rate| per axis over a sliding window, subtracts an offset from the
// selected axis, classifies it against a band and latches movement after the
// value has stayed in band for the dwell time.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake             contents
//  s_axis    in         tvalid/tready         rate_x, rate_z, now_ms
//  m_axis    out        tvalid/tready         band_status, movement, average
//  apb       in         psel/penable/pready   six config registers, 4*i
//
// An item passes the accept, history read, sum update, divide and classify
// steps before the next accept. The restoring divider produces one quotient
// bit per cycle over SUM_W bits, where SUM_W = RATE_BITS + clog2(WINDOW+1);
// a new sample is not taken until the current one has been classified.
// A new sample is accepted while the previous result still waits on m_axis;
// the classify step holds until the output register is free.
// Synchronous reset clears sums, fill count, detection state and registers;
// the history memory is not cleared and its read data is only used once it has been filled.
//
module gyro_band_dwell_detector
  import gbdd_pkg::*;
#(
  parameter int  WINDOW    = WINDOW_DEF,
  parameter int  RATE_BITS = RATE_BITS_DEF,
  localparam int IN_W      = ((2 * RATE_BITS + 32 + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst,
  // sample stream
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [IN_W-1:0]   s_axis_tdata,   // rate_x, rate_z, now_ms, zero pad
  // result stream
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [OUT_W-1:0]  m_axis_tdata,   // band_status, movement_detected,
                                            // averaged_rate, zero pad
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int IDX_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int SUM_W  = RATE_BITS + CNT_W;
  localparam int DCNT_W = $clog2(SUM_W + 1);
  localparam int VAL_W  = SUM_W + 2;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic               armed;
  logic               axis_select;
  logic signed [15:0] low_bound;
  logic signed [15:0] high_bound;
  logic [31:0]        dwell_ms;
  logic [7:0]         rate_offset;

  logic                 cfg_wr;
  logic                 cfg_hit;
  logic [REG_IDX_W-1:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[REG_IDX_W+1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  // Decode a valid register index
  always_comb begin
    case (cfg_idx)
      REG_ARMED, REG_AXIS_SELECT, REG_LOW_BOUND,
      REG_HIGH_BOUND, REG_DWELL_MS, REG_RATE_OFFSET: cfg_hit = 1'b1;
      default:                                       cfg_hit = 1'b0;
    endcase
  end

  // Write the addressed register
  always_ff @(posedge clk) begin
    if (rst) begin
      armed       <= 1'b0;
      axis_select <= 1'b0;
      low_bound   <= '0;
      high_bound  <= '0;
      dwell_ms    <= '0;
      rate_offset <= RATE_OFFSET_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_ARMED:       armed       <= pwdata[0];
        REG_AXIS_SELECT: axis_select <= pwdata[0];
        REG_LOW_BOUND:   low_bound   <= pwdata[15:0];
        REG_HIGH_BOUND:  high_bound  <= pwdata[15:0];
        REG_DWELL_MS:    dwell_ms    <= pwdata;
        REG_RATE_OFFSET: rate_offset <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    case (cfg_idx)
      REG_ARMED:       prdata = {31'd0, armed};
      REG_AXIS_SELECT: prdata = {31'd0, axis_select};
      REG_LOW_BOUND:   prdata = {16'd0, low_bound};
      REG_HIGH_BOUND:  prdata = {16'd0, high_bound};
      REG_DWELL_MS:    prdata = dwell_ms;
      REG_RATE_OFFSET: prdata = {24'd0, rate_offset};
      default:         prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  state_t state, state_next;

  logic              take_in;
  logic              do_read;
  logic              do_update;
  logic              do_div;
  logic              do_commit;
  logic              out_free;
  logic [DCNT_W-1:0] div_cnt;

  assign out_free = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (s_axis_tvalid) state_next = S_READ;
      S_READ:   state_next = S_UPDATE;
      S_UPDATE: state_next = S_DIV;
      S_DIV:    if (div_cnt == DCNT_W'(SUM_W - 1)) state_next = S_CLASS;
      S_CLASS:  if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    s_axis_tready = 1'b0;
    do_read       = 1'b0;
    do_update     = 1'b0;
    do_div        = 1'b0;
    do_commit     = 1'b0;
    case (state)
      S_IDLE:   s_axis_tready = 1'b1;
      S_READ:   do_read       = 1'b1;
      S_UPDATE: do_update     = 1'b1;
      S_DIV:    do_div        = 1'b1;
      S_CLASS:  do_commit     = out_free;
      default: ;
    endcase
  end

  assign take_in = s_axis_tvalid && s_axis_tready;

  // --------------------------------------------------------------------------
  // Input capture: absolute rates and timestamp
  // --------------------------------------------------------------------------
  logic [RATE_BITS-1:0] raw_x, raw_z, abs_x, abs_z;
  logic [RATE_BITS-1:0] in_x, in_z;
  logic [31:0]          in_now;

  assign raw_x = s_axis_tdata[RATE_BITS-1:0];
  assign raw_z = s_axis_tdata[2*RATE_BITS-1:RATE_BITS];
  // The most negative code maps to its magnitude as an unsigned value
  assign abs_x = raw_x[RATE_BITS-1] ? RATE_BITS'(~raw_x + 1'b1) : raw_x;
  assign abs_z = raw_z[RATE_BITS-1] ? RATE_BITS'(~raw_z + 1'b1) : raw_z;

  always_ff @(posedge clk) begin
    if (take_in) begin
      in_x   <= abs_x;
      in_z   <= abs_z;
      in_now <= s_axis_tdata[2*RATE_BITS+31:2*RATE_BITS];
    end
  end

  // --------------------------------------------------------------------------
  // History memory, both axes in one word
  // --------------------------------------------------------------------------
  logic [2*RATE_BITS-1:0] hist [WINDOW];
  logic [2*RATE_BITS-1:0] rd_data;
  logic [IDX_W-1:0]       write_slot;
  logic [CNT_W-1:0]       fill_count;

  always_ff @(posedge clk) begin
    if (do_read)   rd_data <= hist[write_slot];
    if (do_update) hist[write_slot] <= {in_z, in_x};
  end

  // --------------------------------------------------------------------------
  // Window sums, fill count and write slot
  // --------------------------------------------------------------------------
  logic [SUM_W-1:0] sum_x, sum_z, sum_x_next, sum_z_next;
  logic [CNT_W-1:0] fill_next;
  logic             full;

  assign full = (fill_count == CNT_W'(WINDOW));

  // Drop the oldest sample once the window is full, add the new one
  always_comb begin
    sum_x_next = sum_x + SUM_W'(in_x)
               - (full ? SUM_W'(rd_data[RATE_BITS-1:0]) : '0);
    sum_z_next = sum_z + SUM_W'(in_z)
               - (full ? SUM_W'(rd_data[2*RATE_BITS-1:RATE_BITS]) : '0);
    fill_next  = full ? fill_count : fill_count + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_x      <= '0;
      sum_z      <= '0;
      fill_count <= '0;
      write_slot <= '0;
    end else if (do_update) begin
      sum_x      <= sum_x_next;
      sum_z      <= sum_z_next;
      fill_count <= fill_next;
      write_slot <= (write_slot == IDX_W'(WINDOW - 1)) ? '0 : write_slot + 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Restoring divider: sum / fill count, one quotient bit per cycle
  // --------------------------------------------------------------------------
  logic [SUM_W-1:0] quo;
  logic [CNT_W-1:0] rem;
  logic [CNT_W-1:0] divisor;
  logic [CNT_W:0]   trial;
  logic             trial_ge;

  assign trial    = {rem, quo[SUM_W-1]};
  assign trial_ge = (trial >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    if (do_update) begin
      quo     <= axis_select ? sum_z_next : sum_x_next;
      divisor <= fill_next;
      rem     <= '0;
      div_cnt <= '0;
    end else if (do_div) begin
      quo     <= {quo[SUM_W-2:0], trial_ge};
      rem     <= trial_ge ? CNT_W'(trial - {1'b0, divisor}) : CNT_W'(trial);
      div_cnt <= div_cnt + 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Offset, saturate and classify
  // --------------------------------------------------------------------------
  logic signed [VAL_W-1:0] val_full;
  logic signed [AVG_W-1:0] val_sat;
  logic                    above, below;
  logic [31:0]             elapsed;

  assign val_full = $signed({2'b00, quo}) - $signed({{(VAL_W-8){1'b0}}, rate_offset});

  always_comb begin
    if (val_full > AVG_MAX)      val_sat = AVG_W'(AVG_MAX);
    else if (val_full < AVG_MIN) val_sat = AVG_W'(AVG_MIN);
    else                         val_sat = AVG_W'(val_full);
  end

  assign above = (val_sat > high_bound);
  assign below = (val_sat < low_bound);

  // --------------------------------------------------------------------------
  // Dwell timer and movement latch
  // --------------------------------------------------------------------------
  logic        movement_latched, movement_next;
  logic        dwell_running, dwell_running_next;
  logic [31:0] dwell_start, dwell_start_next;
  logic [1:0]  last_status, status_next;

  assign elapsed = in_now - dwell_start;

  always_comb begin
    movement_next      = movement_latched;
    dwell_running_next = dwell_running;
    dwell_start_next   = dwell_start;
    status_next        = last_status;
    if (!armed) begin
      movement_next      = 1'b0;
      dwell_running_next = 1'b0;
      dwell_start_next   = '0;
      status_next        = STATUS_IDLE;
    end else if (movement_latched) begin
      status_next = last_status;
    end else if (above) begin
      dwell_running_next = 1'b0;
      dwell_start_next   = '0;
      status_next        = STATUS_ABOVE;
    end else if (below) begin
      dwell_running_next = 1'b0;
      dwell_start_next   = '0;
      status_next        = STATUS_BELOW;
    end else begin
      status_next = STATUS_IN_BAND;
      if (!dwell_running) begin
        dwell_running_next = 1'b1;
        dwell_start_next   = in_now;
      end else if (elapsed >= dwell_ms) begin
        movement_next      = 1'b1;
        dwell_running_next = 1'b0;
        dwell_start_next   = '0;
      end
    end
  end

  // Clear on any valid config write, advance on commit
  always_ff @(posedge clk) begin
    if (rst || (cfg_wr && cfg_hit)) begin
      movement_latched <= 1'b0;
      dwell_running    <= 1'b0;
      dwell_start      <= '0;
      last_status      <= STATUS_IDLE;
    end else if (do_commit) begin
      movement_latched <= movement_next;
      dwell_running    <= dwell_running_next;
      dwell_start      <= dwell_start_next;
      last_status      <= status_next;
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (do_commit) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_commit) begin
      m_axis_tdata <= {{(OUT_W - AVG_W - 3){1'b0}}, val_sat, movement_next, status_next};
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= CNT_W'(WINDOW))
    else $error("fill count beyond window");

  a_slot_bound: assert property (@(posedge clk) disable iff (rst)
    write_slot <= IDX_W'(WINDOW - 1))
    else $error("write slot beyond window");

  a_slot_tracks_fill: assert property (@(posedge clk) disable iff (rst)
    !full |-> (CNT_W'(write_slot) == fill_count))
    else $error("write slot out of step with fill count while filling");

  a_latch_stops_timer: assert property (@(posedge clk) disable iff (rst)
    movement_latched |-> !dwell_running)
    else $error("dwell timer running after movement latched");

  a_load_from_class: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> ($past(state) == S_CLASS))
    else $error("result loaded outside classify step");

endmodule
